// ===== design/rpip_pkg.sv =====
// Types and character constants shared by the radix-prefixed integer parser.
`timescale 1ns / 1ps

package rpip_pkg;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_BIN = 2'd1,
		RADIX_OCT = 2'd2,
		RADIX_HEX = 2'd3
	} radix_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [3:0] LETTER_BASE = 4'd10;
	localparam logic [7:0] PREFIX_MIN_LEN = 8'd2;

	typedef struct packed {
		logic [63:0] value;
		logic        bad_digit;
		radix_t      radix;
		logic        prefix_pending;
	} acc_result_t;

endpackage

// ===== design/rpip_digit.sv =====
// Character to digit decode and validity check against the current radix.
`timescale 1ns / 1ps

module rpip_digit (
	input  logic [7:0]      ch,
	input  rpip_pkg::radix_t radix,
	output logic [3:0]      digit,
	output logic            ok
);

	logic [7:0] off;
	logic [4:0] base;
	logic       is_dec;
	logic       is_lo;
	logic       is_up;

	always_comb begin
		is_dec = (ch >= rpip_pkg::CH_ZERO) && (ch <= rpip_pkg::CH_NINE);
		is_lo  = (ch >= rpip_pkg::CH_LO_A) && (ch <= rpip_pkg::CH_LO_F);
		is_up  = (ch >= rpip_pkg::CH_UP_A) && (ch <= rpip_pkg::CH_UP_F);
		case (radix)
			rpip_pkg::RADIX_BIN: base = 5'd2;
			rpip_pkg::RADIX_OCT: base = 5'd8;
			rpip_pkg::RADIX_HEX: base = 5'd16;
			default:             base = 5'd10;
		endcase
		if (is_dec) begin
			off   = ch - rpip_pkg::CH_ZERO;
			digit = off[3:0];
		end else if (is_lo) begin
			off   = ch - rpip_pkg::CH_LO_A;
			digit = off[3:0] + rpip_pkg::LETTER_BASE;
		end else if (is_up) begin
			off   = ch - rpip_pkg::CH_UP_A;
			digit = off[3:0] + rpip_pkg::LETTER_BASE;
		end else begin
			off   = 8'd0;
			digit = 4'd0;
		end
		ok = (is_dec || ((is_lo || is_up) && radix == rpip_pkg::RADIX_HEX))
			&& ({1'b0, digit} < base);
	end

endmodule

// ===== design/rpip_acc.sv =====
// Literal state: prefix detection, radix selection and the wrapping accumulator.
`timescale 1ns / 1ps

module rpip_acc #(
	parameter int MAX_TEXT_LENGTH = 255
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             ch,
	input  logic [7:0]             text_length,
	input  logic                   last_char,
	output rpip_pkg::acc_result_t  res
);

	localparam int PosW = $clog2(MAX_TEXT_LENGTH + 1);
	localparam logic [PosW-1:0] PosMax = PosW'(MAX_TEXT_LENGTH);

	logic [PosW-1:0]  pos_q;
	rpip_pkg::radix_t radix_q;
	logic [63:0]      acc_q;
	logic             err_q;
	logic             pend_q;

	rpip_pkg::radix_t radix_d;
	logic             pend_d;
	logic             take;
	logic [3:0]       digit;
	logic             ok;
	logic [63:0]      scaled;

	rpip_digit u_digit (
		.ch    (ch),
		.radix (radix_d),
		.digit (digit),
		.ok    (ok)
	);

	always_comb begin
		radix_d = radix_q;
		pend_d  = pend_q;
		take    = 1'b1;
		if (pos_q == '0) begin
			if (text_length > rpip_pkg::PREFIX_MIN_LEN && ch == rpip_pkg::CH_ZERO) begin
				pend_d  = 1'b1;
				radix_d = rpip_pkg::RADIX_OCT;
				take    = 1'b0;
			end else begin
				radix_d = rpip_pkg::RADIX_DEC;
			end
		end else if (pend_q) begin
			pend_d = 1'b0;
			if (ch == rpip_pkg::CH_LO_B || ch == rpip_pkg::CH_UP_B) begin
				radix_d = rpip_pkg::RADIX_BIN;
				take    = 1'b0;
			end else if (ch == rpip_pkg::CH_LO_X || ch == rpip_pkg::CH_UP_X) begin
				radix_d = rpip_pkg::RADIX_HEX;
				take    = 1'b0;
			end else begin
				radix_d = rpip_pkg::RADIX_OCT;
			end
		end
		case (radix_d)
			rpip_pkg::RADIX_BIN: scaled = {acc_q[62:0], 1'b0};
			rpip_pkg::RADIX_OCT: scaled = {acc_q[60:0], 3'b000};
			rpip_pkg::RADIX_HEX: scaled = {acc_q[59:0], 4'b0000};
			default:             scaled = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0};
		endcase
		res.radix          = radix_d;
		res.prefix_pending = pend_d;
		res.value          = take ? scaled + {60'd0, (ok ? digit : 4'd0)} : acc_q;
		res.bad_digit      = err_q | (take & ~ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			radix_q <= rpip_pkg::RADIX_DEC;
			acc_q   <= 64'd0;
			err_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else if (step) begin
			if (last_char) begin
				pos_q   <= '0;
				radix_q <= rpip_pkg::RADIX_DEC;
				acc_q   <= 64'd0;
				err_q   <= 1'b0;
				pend_q  <= 1'b0;
			end else begin
				if (pos_q < PosMax)
					pos_q <= pos_q + 1'b1;
				radix_q <= radix_d;
				acc_q   <= res.value;
				err_q   <= res.bad_digit;
				pend_q  <= pend_d;
			end
		end
	end

endmodule

// ===== design/radix_prefixed_integer_parser.sv =====
// Top level of the radix-prefixed integer parser: input word register, state, result register.
//  channel | dir | tdata                          | tuser / tlast
//  s_*     | in  | ch [7:0], text_length [15:8]   | tlast = last_char
//  m_*     | out | value [63:0]                   | tuser: bad_digit [0], radix_used [2:1]
// One character word per cycle unless a result stalls; a result passes both registers.
// The input register and the 64-bit multiply-add on the accumulator set the rate.
// Reset clears all literal state and both valid flags; no clearing pass.
// A stalled result holds the input register only when that register holds another last word.
`timescale 1ns / 1ps

module radix_prefixed_integer_parser #(
	parameter int MAX_TEXT_LENGTH = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // ch [7:0], text_length [15:8]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // value [63:0]
	output logic [2:0]  m_tuser    // bad_digit [0], radix_used [2:1]
);

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic [7:0]  len_s1;
	logic        last_s1;
	logic        out_free;
	logic        adv;

	rpip_pkg::acc_result_t res;

	assign out_free = ~m_tvalid | m_tready;
	assign adv      = valid_s1 & (~last_s1 | out_free);
	assign s_tready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata[7:0];
			len_s1  <= s_tdata[15:8];
			last_s1 <= s_tlast;
		end
	end

	rpip_acc #(
		.MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
	) u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.ch          (ch_s1),
		.text_length (len_s1),
		.last_char   (last_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv && last_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			m_tdata <= res.value;
			m_tuser <= {res.radix, res.bad_digit};
		end
	end

	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(adv && last_s1))
		else $error("result raised without a last word");

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |-> (last_s1 && m_tvalid && !m_tready))
		else $error("input register held without a blocked result");

	a_pending_is_octal: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.prefix_pending) |-> (res.radix == rpip_pkg::RADIX_OCT))
		else $error("prefix pending outside octal");

endmodule

// ===== tb/radix_prefixed_integer_parser_test.sv =====
// Self-checking testbench for the radix-prefixed integer parser.
`timescale 1ns / 1ps

module radix_prefixed_integer_parser_test;

	localparam int MAX_TEXT_LENGTH = 255;
	localparam int ITEM_TARGET = 1350;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] text_length;
		logic       last_char;
	} char_word_t;

	typedef struct packed {
		logic [63:0]      value;
		logic             bad_digit;
		rpip_pkg::radix_t radix_used;
	} literal_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // ch [7:0], text_length [15:8]
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // value [63:0]
	logic [2:0]  m_tuser;        // bad_digit [0], radix_used [2:1]

	radix_prefixed_integer_parser #(
		.MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	char_word_t      char_feed[$];
	logic [7:0]      lit_chars[$];
	literal_result_t expected_literals[$];

	logic [7:0]       lit_pos = '0;
	rpip_pkg::radix_t lit_radix = rpip_pkg::RADIX_DEC;
	logic [63:0]      lit_acc = '0;
	logic             lit_err = 1'b0;
	logic             lit_prefix = 1'b0;

	logic in_taken = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	bit   send_calm = 0;
	bit   sink_calm = 0;
	int   fails = 0;
	int   words_taken = 0;
	int   literals_done = 0;
	int   bad_results = 0;
	int   radix_hits[4] = '{0, 0, 0, 0};

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int d;
		d = $urandom_range(0, 15);
		if (d < 10)
			return 8'(rpip_pkg::CH_ZERO + d);
		return 8'(($urandom_range(0, 1) ? rpip_pkg::CH_LO_A : rpip_pkg::CH_UP_A) + d
			- rpip_pkg::LETTER_BASE);
	endfunction

	task automatic absorb_digit(input logic [7:0] c);
		logic [63:0] base;
		logic [63:0] digit;
		logic        ok;
		case (lit_radix)
			rpip_pkg::RADIX_BIN: base = 64'd2;
			rpip_pkg::RADIX_OCT: base = 64'd8;
			rpip_pkg::RADIX_HEX: base = 64'd16;
			default:             base = 64'd10;
		endcase
		ok = 1'b1;
		digit = '0;
		if (c >= rpip_pkg::CH_ZERO && c <= rpip_pkg::CH_NINE) begin
			digit = c - rpip_pkg::CH_ZERO;
		end else if (c >= rpip_pkg::CH_LO_A && c <= rpip_pkg::CH_LO_F) begin
			digit = c - rpip_pkg::CH_LO_A + rpip_pkg::LETTER_BASE;
			ok = (lit_radix == rpip_pkg::RADIX_HEX);
		end else if (c >= rpip_pkg::CH_UP_A && c <= rpip_pkg::CH_UP_F) begin
			digit = c - rpip_pkg::CH_UP_A + rpip_pkg::LETTER_BASE;
			ok = (lit_radix == rpip_pkg::RADIX_HEX);
		end else begin
			ok = 1'b0;
		end
		if (digit >= base)
			ok = 1'b0;
		if (!ok) begin
			digit = '0;
			lit_err = 1'b1;
		end
		lit_acc = lit_acc * base + digit;
	endtask

	task automatic parse_char(input char_word_t w);
		literal_result_t r;
		if (lit_pos == 0) begin
			if (w.text_length > rpip_pkg::PREFIX_MIN_LEN && w.ch == rpip_pkg::CH_ZERO) begin
				lit_prefix = 1'b1;
				lit_radix = rpip_pkg::RADIX_OCT;
			end else begin
				lit_radix = rpip_pkg::RADIX_DEC;
				absorb_digit(w.ch);
			end
		end else if (lit_prefix) begin
			lit_prefix = 1'b0;
			if (w.ch == rpip_pkg::CH_LO_B || w.ch == rpip_pkg::CH_UP_B) begin
				lit_radix = rpip_pkg::RADIX_BIN;
			end else if (w.ch == rpip_pkg::CH_LO_X || w.ch == rpip_pkg::CH_UP_X) begin
				lit_radix = rpip_pkg::RADIX_HEX;
			end else begin
				lit_radix = rpip_pkg::RADIX_OCT;
				absorb_digit(w.ch);
			end
		end else begin
			absorb_digit(w.ch);
		end
		if (lit_pos < MAX_TEXT_LENGTH)
			lit_pos = lit_pos + 1'b1;
		if (w.last_char) begin
			r.value = lit_acc;
			r.bad_digit = lit_err;
			r.radix_used = lit_radix;
			expected_literals.push_back(r);
			lit_pos = '0;
			lit_radix = rpip_pkg::RADIX_DEC;
			lit_acc = '0;
			lit_err = 1'b0;
			lit_prefix = 1'b0;
		end
	endtask

	task automatic emit_literal(input logic [7:0] len);
		char_word_t w;
		foreach (lit_chars[i]) begin
			w.ch = lit_chars[i];
			w.text_length = len;
			w.last_char = (i == lit_chars.size() - 1);
			char_feed.push_back(w);
		end
		lit_chars.delete();
	endtask

	task automatic emit_text(input string s, input logic [7:0] len);
		for (int i = 0; i < s.len(); i++)
			lit_chars.push_back(s[i]);
		emit_literal(len);
	endtask

	task automatic make_literal();
		int kind;
		int n;
		int pick;
		logic [7:0] len;
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			n = $urandom_range(0, 5) == 0 ? $urandom_range(15, 25) : $urandom_range(1, 8);
			repeat (n) lit_chars.push_back(8'(rpip_pkg::CH_ZERO + $urandom_range(0, 9)));
		end else if (kind < 45) begin
			lit_chars.push_back(rpip_pkg::CH_ZERO);
			lit_chars.push_back($urandom_range(0, 1) ? rpip_pkg::CH_LO_X : rpip_pkg::CH_UP_X);
			n = $urandom_range(0, 4) == 0 ? $urandom_range(14, 20) : $urandom_range(1, 8);
			repeat (n) lit_chars.push_back(rand_hex_char());
		end else if (kind < 60) begin
			lit_chars.push_back(rpip_pkg::CH_ZERO);
			lit_chars.push_back($urandom_range(0, 1) ? rpip_pkg::CH_LO_B : rpip_pkg::CH_UP_B);
			n = $urandom_range(0, 5) == 0 ? $urandom_range(60, 70) : $urandom_range(1, 12);
			repeat (n) lit_chars.push_back(8'(rpip_pkg::CH_ZERO + $urandom_range(0, 1)));
		end else if (kind < 72) begin
			lit_chars.push_back(rpip_pkg::CH_ZERO);
			n = $urandom_range(0, 5) == 0 ? $urandom_range(20, 24) : $urandom_range(1, 8);
			repeat (n) lit_chars.push_back(8'(rpip_pkg::CH_ZERO + $urandom_range(0, 7)));
		end else if (kind < 80) begin
			lit_chars.push_back(rpip_pkg::CH_ZERO);
			case ($urandom_range(0, 2))
				0: ;
				1: lit_chars.push_back($urandom_range(0, 1) ? rpip_pkg::CH_LO_X
					: rpip_pkg::CH_UP_X);
				default: lit_chars.push_back($urandom_range(0, 1) ? rpip_pkg::CH_LO_B
					: rpip_pkg::CH_UP_B);
			endcase
			emit_literal(8'($urandom_range(1, 6)));
			return;
		end else if (kind < 90) begin
			lit_chars.push_back(rpip_pkg::CH_ZERO);
			lit_chars.push_back($urandom_range(0, 1) ? rpip_pkg::CH_LO_X : rpip_pkg::CH_LO_B);
			n = $urandom_range(1, 8);
			repeat (n) lit_chars.push_back(rand_hex_char());
			pick = $urandom_range(0, lit_chars.size() - 1);
			lit_chars[pick] = 8'($urandom_range(0, 255));
		end else if (kind < 96) begin
			n = $urandom_range(1, 10);
			repeat (n) lit_chars.push_back($urandom_range(0, 1) ? rand_hex_char()
				: rpip_pkg::CH_ZERO);
			emit_literal(8'($urandom_range(1, 255)));
			return;
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) lit_chars.push_back(8'($urandom_range(0, 255)));
			emit_literal(8'($urandom_range(1, 255)));
			return;
		end
		len = lit_chars.size() > 255 ? 8'd255 : 8'(lit_chars.size());
		emit_literal(len);
	endtask

	// advance the sender once the current word is taken
	always @(negedge clk) begin
		char_word_t w;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap = send_gap - 1;
			end else if (char_feed.size() != 0) begin
				w = char_feed.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {w.text_length, w.ch};
				s_tlast <= w.last_char;
				if ($urandom_range(0, 49) == 0)
					send_calm = ~send_calm;
				send_gap = pick_gap(send_calm);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left = stall_left - 1;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 49) == 0)
					sink_calm = ~sink_calm;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap(sink_calm);
			end
		end
	end

	always @(posedge clk) begin
		literal_result_t exp_r;
		char_word_t w;
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			literals_done++;
			if (m_tuser[0])
				bad_results++;
			radix_hits[m_tuser[2:1]]++;
			if (expected_literals.size() == 0) begin
				fails++;
				if (fails <= REPORT_LIMIT)
					$display("unexpected result: value %h bad_digit %b radix %0d",
						m_tdata, m_tuser[0], m_tuser[2:1]);
			end else begin
				exp_r = expected_literals.pop_front();
				if (m_tdata !== exp_r.value || m_tuser[0] !== exp_r.bad_digit ||
						m_tuser[2:1] !== exp_r.radix_used) begin
					fails++;
					if (fails <= REPORT_LIMIT)
						$display("result %0d: value %h/%h bad_digit %b/%b radix %0d/%0d %s",
							literals_done, exp_r.value, m_tdata, exp_r.bad_digit,
							m_tuser[0], exp_r.radix_used, m_tuser[2:1], "(expected/actual)");
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			w.ch = s_tdata[7:0];
			w.text_length = s_tdata[15:8];
			w.last_char = s_tlast;
			words_taken++;
			parse_char(w);
		end
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		emit_text("7", 8'd1);
		lit_chars.push_back(8'hFF);
		emit_literal(8'd255);
		lit_chars.push_back(8'h00);
		emit_literal(8'd1);
		emit_text("0", 8'd3);
		emit_text("0x", 8'd3);
		emit_text("0B", 8'd3);
		emit_text("0b101", 8'd5);
		emit_text("0XaF", 8'd4);
		emit_text("017", 8'd3);
		emit_text("09", 8'd2);
		emit_text("1c", 8'd2);

		// one overlong literal to push the position counter into saturation
		lit_chars.push_back(rpip_pkg::CH_ZERO);
		lit_chars.push_back(rpip_pkg::CH_LO_X);
		repeat (258) lit_chars.push_back(rand_hex_char());
		emit_literal(8'd255);

		while (char_feed.size() < ITEM_TARGET)
			make_literal();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (char_feed.size() != 0 || s_tvalid)
			@(negedge clk);
		while (expected_literals.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("%0d characters in, %0d literals out, %0d flagged with bad digits",
			words_taken, literals_done, bad_results);
		$display("results by radix: dec %0d, bin %0d, oct %0d, hex %0d; %0d mismatches",
			radix_hits[rpip_pkg::RADIX_DEC], radix_hits[rpip_pkg::RADIX_BIN],
			radix_hits[rpip_pkg::RADIX_OCT], radix_hits[rpip_pkg::RADIX_HEX], fails);
		if (fails == 0 && expected_literals.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
